// ===== hdl/wcue_pkg.sv =====
// ----------------------------------------------------------------------------
// wcue_pkg
// Constants and helper functions for the URL-escaped UTF-8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wcue_pkg;

    localparam int unsigned CpWidth   = 31;
    localparam int unsigned DigitBits = 6;
    // Continuation bits still waiting after the lead byte: five digits at most.
    localparam int unsigned ContWidth = 5 * DigitBits;

    localparam logic [CpWidth-1:0] SurrHiLo  = 31'h0000_D800;
    localparam logic [CpWidth-1:0] SurrHiHi  = 31'h0000_DBFF;
    localparam logic [CpWidth-1:0] Lim1Byte  = 31'h0000_0080;
    localparam logic [CpWidth-1:0] Lim2Byte  = 31'h0000_0800;
    localparam logic [CpWidth-1:0] Lim3Byte  = 31'h0001_0000;
    localparam logic [CpWidth-1:0] Lim4Byte  = 31'h0020_0000;
    localparam logic [CpWidth-1:0] Lim5Byte  = 31'h0400_0000;

    localparam logic [7:0] Lead2     = 8'hC0;
    localparam logic [7:0] Lead3     = 8'hE0;
    localparam logic [7:0] Lead4     = 8'hF0;
    localparam logic [7:0] Lead5     = 8'hF8;
    localparam logic [7:0] Lead6     = 8'hFC;
    localparam logic [1:0] ContMark  = 2'b10;
    localparam logic [7:0] Percent   = 8'h25;

    typedef logic [2:0] nbytes_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    // True for the bytes that go out unescaped.
    function automatic logic byte_passes(input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (b >= 8'h30 && b <= 8'h39) ok = 1'b1;
        if (b >= 8'h40 && b <= 8'h5A) ok = 1'b1;
        if (b >= 8'h61 && b <= 8'h7A) ok = 1'b1;
        if (b == 8'h2A || b == 8'h2D || b == 8'h2E || b == 8'h5F) ok = 1'b1;
        return ok;
    endfunction

    // Uppercase ASCII hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = 8'h30 + {4'h0, n};
        else
            c = 8'h37 + {4'h0, n};
        return c;
    endfunction

endpackage : wcue_pkg

`default_nettype wire

// ===== hdl/wide_char_to_url_escaped_utf8.sv =====
// ----------------------------------------------------------------------------
// wide_char_to_url_escaped_utf8
// Encodes one code point per transaction as UTF-8 (1 to 6 byte form) and
// sends each byte URL-escaped if needed, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
//   Channel | Handshake            | Payload
//   --------+----------------------+----------------------------------
//   input   | in_valid / in_ready  | code_point[30:0], string_end
//   output  | out_valid/ out_ready | out_char[7:0], run_last
//
// An input transaction is accepted while the encoder is idle; then each UTF-8
// byte goes out as itself if it passes unescaped, or as a percent sign and two
// hex digits if it is escaped; the code point shifts out one 6-bit digit per byte.
// Items that give no characters are absorbed in the accepting cycle.
// A stall on the output simply holds the emitter; the next input transaction
// is accepted as soon as the last character sits in the output register.
// Reset (rst_n low) clears the truncation flag and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_char_to_url_escaped_utf8 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [wcue_pkg::CpWidth-1:0] code_point,
    input  wire logic                        string_end,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_char,
    output logic                             run_last
);

    import wcue_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    phase_t                 ph_reg, ph_next;
    logic                   trunc_reg, trunc_next;
    logic [7:0]             byte_reg, byte_next;
    logic [ContWidth-1:0]   sr_reg, sr_next;
    nbytes_t                left_reg, left_next;
    logic                   ovalid_reg, ovalid_next;
    logic [7:0]             ochar_reg, ochar_next;
    logic                   olast_reg, olast_next;

    logic                   in_accept;
    logic                   high_surr;
    logic                   trunc_eff;
    logic                   start;
    nbytes_t                nbytes;
    logic [7:0]             lead;
    logic [ContWidth+6:0]   aligned;
    logic                   out_free;
    logic                   cur_pass;
    logic [7:0]             emit_char;
    logic                   emit_last;
    logic                   byte_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign run_last  = olast_reg;

    assign high_surr = (code_point >= SurrHiLo) && (code_point <= SurrHiHi);
    assign trunc_eff = trunc_reg || high_surr;
    assign start     = in_accept && !trunc_eff && (code_point != '0);
    assign out_free  = !ovalid_reg || out_ready;
    assign cur_pass  = byte_passes(byte_reg);

    always_comb
    begin
        if (code_point < Lim1Byte)
        begin
            nbytes = 3'd1;
            lead   = 8'h00;
        end
        else if (code_point < Lim2Byte)
        begin
            nbytes = 3'd2;
            lead   = Lead2;
        end
        else if (code_point < Lim3Byte)
        begin
            nbytes = 3'd3;
            lead   = Lead3;
        end
        else if (code_point < Lim4Byte)
        begin
            nbytes = 3'd4;
            lead   = Lead4;
        end
        else if (code_point < Lim5Byte)
        begin
            nbytes = 3'd5;
            lead   = Lead5;
        end
        else
        begin
            nbytes = 3'd6;
            lead   = Lead6;
        end
    end

    // Left-align the code point so the lead byte's bits sit in the top seven
    // places and the continuation digits follow below it, most significant first.
    always_comb
    begin
        case (nbytes)
            3'd1:    aligned = {6'b0, code_point} << (5 * DigitBits);
            3'd2:    aligned = {6'b0, code_point} << (4 * DigitBits);
            3'd3:    aligned = {6'b0, code_point} << (3 * DigitBits);
            3'd4:    aligned = {6'b0, code_point} << (2 * DigitBits);
            3'd5:    aligned = {6'b0, code_point} << (1 * DigitBits);
            default: aligned = {6'b0, code_point};
        endcase
    end

    always_comb
    begin
        case (ph_reg)
            PH_FIRST:
            begin
                emit_char = cur_pass ? byte_reg : Percent;
                emit_last = cur_pass && (left_reg == '0);
                byte_done = cur_pass;
            end
            PH_HIGH:
            begin
                emit_char = hex_digit(byte_reg[7:4]);
                emit_last = 1'b0;
                byte_done = 1'b0;
            end
            default:
            begin
                emit_char = hex_digit(byte_reg[3:0]);
                emit_last = (left_reg == '0);
                byte_done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        trunc_next  = trunc_reg;
        byte_next   = byte_reg;
        sr_next     = sr_reg;
        left_next   = left_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;

        if (in_accept)
        begin
            trunc_next = string_end ? 1'b0 : trunc_eff;
            if (start)
            begin
                state_next = ST_EMIT;
                ph_next    = PH_FIRST;
                byte_next  = {1'b0, aligned[ContWidth+6:ContWidth]} | lead;
                sr_next    = aligned[ContWidth-1:0];
                left_next  = nbytes - 3'd1;
            end
        end
        else if (state_reg == ST_EMIT && out_free)
        begin
            ovalid_next = 1'b1;
            ochar_next  = emit_char;
            olast_next  = emit_last;
            if (!byte_done)
            begin
                ph_next = (ph_reg == PH_FIRST) ? PH_HIGH : PH_LOW;
            end
            else if (left_reg == '0)
            begin
                state_next = ST_IDLE;
                ph_next    = PH_FIRST;
            end
            else
            begin
                ph_next   = PH_FIRST;
                byte_next = {ContMark, sr_reg[ContWidth-1 -: DigitBits]};
                sr_next   = sr_reg << DigitBits;
                left_next = left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ph_reg     <= PH_FIRST;
            trunc_reg  <= 1'b0;
            byte_reg   <= '0;
            sr_reg     <= '0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
            ochar_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ph_reg     <= ph_next;
            trunc_reg  <= trunc_next;
            byte_reg   <= byte_next;
            sr_reg     <= sr_next;
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
            ochar_reg  <= ochar_next;
            olast_reg  <= olast_next;
        end
    end

    // The hex digit phases only ever run on a byte that needs escaping.
    a_hex_only_escaped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && ph_reg != PH_FIRST) |-> !cur_pass)
        else $error("hex phase on a byte that passes unescaped");

    // Loading the final character of a run hands control back to the input.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && byte_done && left_reg == '0)
            |=> (state_reg == ST_IDLE && olast_reg))
        else $error("final character did not end the run");

    // A high surrogate without the end mark leaves the string truncated.
    a_surrogate_truncates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && high_surr && !string_end) |=> (trunc_reg && state_reg == ST_IDLE))
        else $error("high surrogate did not truncate");

    // No more than five continuation bytes ever remain, and the phase stays legal.
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (left_reg <= 3'd5 && ph_reg != 2'd3))
        else $error("byte counter or phase out of range");

endmodule : wide_char_to_url_escaped_utf8

`default_nettype wire
